>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every edge outside reset
`define GEWD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication outside reset
`define GEWD_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

>>> rtl/gewd_pkg.sv
`timescale 1ns / 1ps

package gewd_pkg;

	localparam int GROUP_SIZE_DEF  = 16;
	localparam int TOTAL_WIDTH_DEF = 40;

	localparam logic [7:0] EXP_BIAS    = 8'd127;
	localparam logic [7:0] EXP_SPECIAL = 8'hFF;
	localparam logic [4:0] EMPTY_LOW   = 5'd16;
	localparam logic [3:0] MINOR_BASE  = 4'd8;
	localparam int         MAG_BITS    = 7;

	typedef enum logic [1:0] {
		MODE_SPAN  = 2'd0,
		MODE_LEAD  = 2'd1,
		MODE_MINOR = 2'd2
	} width_mode_t;

	// exponent bits for the tracked range, 0 for an empty group
	function automatic logic [3:0] group_width_f(input logic [1:0] mode,
			input logic [4:0] lo, input logic [3:0] hi);
		logic [3:0] w;
		if (lo > {1'b0, hi}) begin
			w = 4'd0;
		end else begin
			case (mode)
				MODE_LEAD:  w = hi + 4'd1;
				MODE_MINOR: w = MINOR_BASE - lo[3:0];
				default:    w = hi - lo[3:0] + 4'd1;
			endcase
		end
		return w;
	endfunction

endpackage

>>> rtl/group_exponent_width_detector_core.sv
`timescale 1ns / 1ps
// group exponent width detector
// input channel: value_word, group_end, tensor_end with word_valid / word_stall;
// an item is taken on a rising edge with word_valid high and word_stall low
// result channel: group_width, nonzero_exponents, group_bits, running_bits with
// result_valid / result_stall; one result per item that carries group_end
// width_mode is written through cfg_write_en / cfg_write_data; the user must
// write it only while idle; the block itself does not enforce this
// throughput: one item per cycle unless result_stall holds the pipeline, set by
// the single update of the group range and count registers in the decode stage
// a result passes the input register, group update, total and output register
// while a result is held by result_stall the whole pipeline freezes and
// word_stall is raised in the same cycle
// reset clears the group range, count, running total, width_mode and all
// valid flags; the block takes items from the first edge after reset
module group_exponent_width_detector_core #(
	parameter int GROUP_SIZE  = gewd_pkg::GROUP_SIZE_DEF,
	parameter int TOTAL_WIDTH = gewd_pkg::TOTAL_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [1:0]             cfg_write_data,
	input  logic                   word_valid,
	output logic                   word_stall,
	input  logic [15:0]            value_word,
	input  logic                   group_end,
	input  logic                   tensor_end,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [3:0]             group_width,
	output logic [4:0]             nonzero_exponents,
	output logic [7:0]             group_bits,
	output logic [TOTAL_WIDTH-1:0] running_bits
);

	localparam int         COUNT_CAP_I = (GROUP_SIZE < 31) ? GROUP_SIZE : 31;
	localparam logic [4:0] COUNT_CAP   = 5'(COUNT_CAP_I);
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

	logic        advance;
	logic [1:0]  width_mode_q;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        gend_s1;
	logic        tend_s1;

	logic [4:0]  lo_q;
	logic [3:0]  hi_q;
	logic [4:0]  count_q;

	logic        valid_s2;
	logic [3:0]  width_s2;
	logic [4:0]  count_s2;
	logic        tend_s2;

	logic [TOTAL_WIDTH-1:0] total_q;
	logic                   result_valid_q;
	logic [3:0]             width_q;
	logic [4:0]             count_out_q;
	logic [7:0]             bits_q;
	logic [TOTAL_WIDTH-1:0] running_q;

	// decode of the registered word
	logic [7:0]  biased;
	logic [7:0]  mag_full;
	logic [6:0]  mag;
	logic        neg;
	logic        takes;
	logic [4:0]  word_lo;
	logic [3:0]  word_hi;
	logic [4:0]  lo_new;
	logic [3:0]  hi_new;
	logic [4:0]  count_new;

	logic [8:0]             prod;
	logic [TOTAL_WIDTH:0]   sum;
	logic [TOTAL_WIDTH-1:0] total_new;

	assign advance    = !(result_valid_q && result_stall);
	assign word_stall = !advance;

	always_comb begin
		biased   = word_s1[14:7];
		neg      = 1'b0;
		mag_full = 8'd0;
		if (biased == gewd_pkg::EXP_SPECIAL) begin
			mag_full = 8'd0;
		end else if (biased < gewd_pkg::EXP_BIAS) begin
			mag_full = gewd_pkg::EXP_BIAS - biased;
			neg      = 1'b1;
		end else begin
			mag_full = biased - gewd_pkg::EXP_BIAS;
		end
		mag   = mag_full[6:0];
		takes = (word_s1[14:0] != 15'd0) && (mag != 7'd0);

		word_lo = 5'd0;
		for (int i = gewd_pkg::MAG_BITS - 1; i >= 0; i--) begin
			if (mag[i]) begin
				word_lo = 5'(i);
			end
		end
		word_hi = 4'd0;
		for (int i = 0; i < gewd_pkg::MAG_BITS; i++) begin
			if (mag[i]) begin
				word_hi = 4'(i);
			end
		end
		word_hi = word_hi + {3'd0, neg};

		lo_new    = lo_q;
		hi_new    = hi_q;
		count_new = count_q;
		if (takes) begin
			if (word_lo < lo_q) begin
				lo_new = word_lo;
			end
			if (word_hi > hi_q) begin
				hi_new = word_hi;
			end
			if (count_q < COUNT_CAP) begin
				count_new = count_q + 5'd1;
			end
		end
	end

	always_comb begin
		prod = 9'(width_s2) * 9'(count_s2);
		sum  = {1'b0, total_q} + (TOTAL_WIDTH + 1)'(prod[7:0]);
		if (sum[TOTAL_WIDTH]) begin
			total_new = TOTAL_MAX;
		end else begin
			total_new = sum[TOTAL_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_mode_q <= gewd_pkg::MODE_SPAN;
		end else if (cfg_write_en) begin
			width_mode_q <= cfg_write_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1 <= value_word;
			gend_s1 <= group_end;
			tend_s1 <= tensor_end;
		end
	end

	// group range and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= gewd_pkg::EMPTY_LOW;
			hi_q     <= 4'd0;
			count_q  <= 5'd0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && gend_s1;
			if (valid_s1) begin
				if (gend_s1) begin
					lo_q    <= gewd_pkg::EMPTY_LOW;
					hi_q    <= 4'd0;
					count_q <= 5'd0;
				end else begin
					lo_q    <= lo_new;
					hi_q    <= hi_new;
					count_q <= count_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			width_s2 <= gewd_pkg::group_width_f(width_mode_q, lo_new, hi_new);
			count_s2 <= count_new;
			tend_s2  <= tend_s1;
		end
	end

	// running total and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q        <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s2;
			if (valid_s2) begin
				total_q <= tend_s2 ? '0 : total_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			width_q     <= width_s2;
			count_out_q <= count_s2;
			bits_q      <= prod[7:0];
			running_q   <= total_new;
		end
	end

	assign result_valid      = result_valid_q;
	assign group_width       = width_q;
	assign nonzero_exponents = count_out_q;
	assign group_bits        = bits_q;
	assign running_bits      = running_q;

`include "assert_macros.svh"

	`GEWD_ASSERT_IMPL(a_empty_has_no_count, result_valid && group_width == 4'd0, nonzero_exponents == 5'd0, "empty group with nonzero count")
	`GEWD_ASSERT_IMPL(a_count_has_width, result_valid && nonzero_exponents == 5'd0, group_width == 4'd0, "width without counted words")
	`GEWD_ASSERT_IMPL(a_empty_state, lo_q == gewd_pkg::EMPTY_LOW, count_q == 5'd0 && hi_q == 4'd0, "empty range with group state set")
	`GEWD_ASSERT(a_count_cap, count_q <= COUNT_CAP, "group count beyond cap")

endmodule

>>> dv/group_exponent_width_detector_core_tb.sv
`timescale 1ns / 1ps

module group_exponent_width_detector_core_tb;

	localparam int TW = gewd_pkg::TOTAL_WIDTH_DEF;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int COUNT_CAP = gewd_pkg::GROUP_SIZE_DEF < 31 ? gewd_pkg::GROUP_SIZE_DEF : 31;
	localparam logic [TW-1:0] TOTAL_MAX = '1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 185;
	localparam int NUM_PHASES = 6;
	localparam int NUM_ROWS = 15;

	typedef struct packed {
		logic [3:0]    width;
		logic [4:0]    count;
		logic [7:0]    gbits;
		logic [TW-1:0] total;
	} group_result_t;

	typedef struct packed {
		logic [15:0]   word;
		logic          ge;
		logic          te;
		logic          typed;
		group_result_t res;
	} stim_row_t;

	localparam group_result_t EMPTY_RES = '0;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_write_en = 1'b0;
	logic [1:0]    cfg_write_data = gewd_pkg::MODE_SPAN;
	logic          word_valid = 1'b0;
	logic [15:0]   value_word = 16'd0;
	logic          group_end = 1'b0;
	logic          tensor_end = 1'b0;
	logic          result_stall = 1'b0;
	logic          word_stall;
	logic          result_valid;
	logic [3:0]    group_width;
	logic [4:0]    nonzero_exponents;
	logic [7:0]    group_bits;
	logic [TW-1:0] running_bits;

	// group tracker state
	logic [1:0]    mode_now;
	logic [4:0]    low_seen;
	logic [3:0]    high_seen;
	logic [4:0]    nz_count;
	logic [TW-1:0] total_bits;

	group_result_t pending_groups[$];
	logic [3:0]    modes_seen = 4'b0001;
	bit            quiet = 1'b0;
	int            stall_left = 0;
	int            errors = 0;
	int            cycles = 0;
	int            words_taken = 0;
	int            groups_seen = 0;

	logic [1:0] phase_modes [NUM_PHASES] =
		'{gewd_pkg::MODE_LEAD, gewd_pkg::MODE_MINOR, MODE_UNUSED, gewd_pkg::MODE_SPAN,
		gewd_pkg::MODE_MINOR, gewd_pkg::MODE_LEAD};

	stim_row_t stim_rows [NUM_ROWS] = '{
		'{16'h0000, 1'b1, 1'b0, 1'b1, EMPTY_RES},  // empty group after reset
		'{16'h8000, 1'b1, 1'b0, 1'b1, EMPTY_RES},  // negative zero
		'{16'h3F80, 1'b0, 1'b0, 1'b0, EMPTY_RES},  // exponent magnitude zero
		'{16'hBFC5, 1'b1, 1'b0, 1'b1, EMPTY_RES},
		'{16'h7F80, 1'b0, 1'b1, 1'b0, EMPTY_RES},  // inf, lone tensor end
		'{16'hFFC1, 1'b1, 1'b1, 1'b1, EMPTY_RES},  // nan
		'{16'h0001, 1'b1, 1'b0, 1'b0, EMPTY_RES},  // subnormal
		'{16'h0080, 1'b0, 1'b0, 1'b0, EMPTY_RES},
		'{16'h7F7F, 1'b1, 1'b0, 1'b0, EMPTY_RES},
		'{16'h4000, 1'b0, 1'b0, 1'b0, EMPTY_RES},
		'{16'hBF00, 1'b0, 1'b0, 1'b0, EMPTY_RES},
		'{16'h4300, 1'b0, 1'b0, 1'b0, EMPTY_RES},
		'{16'h4B00, 1'b1, 1'b1, 1'b0, EMPTY_RES},
		'{16'hFFFF, 1'b0, 1'b1, 1'b0, EMPTY_RES},
		'{16'h0000, 1'b1, 1'b0, 1'b1, EMPTY_RES}
	};

	group_exponent_width_detector_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write_en      (cfg_write_en),
		.cfg_write_data    (cfg_write_data),
		.word_valid        (word_valid),
		.word_stall        (word_stall),
		.value_word        (value_word),
		.group_end         (group_end),
		.tensor_end        (tensor_end),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.group_width       (group_width),
		.nonzero_exponents (nonzero_exponents),
		.group_bits        (group_bits),
		.running_bits      (running_bits)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic track_word(input logic [15:0] w, input logic ge, input logic te,
			output logic has_res, output group_result_t res);
		logic [7:0]  biased;
		logic [7:0]  mag;
		logic        neg;
		int          lob;
		int          hib;
		int          width;
		int          i;
		logic [TW:0] sum;
		biased = w[14:7];
		mag = 8'd0;
		neg = 1'b0;
		has_res = 1'b0;
		res = '0;
		if (w[14:0] != 15'd0) begin
			if (biased == gewd_pkg::EXP_SPECIAL) begin
				mag = 8'd0;
			end else if (biased < gewd_pkg::EXP_BIAS) begin
				mag = gewd_pkg::EXP_BIAS - biased;
				neg = 1'b1;
			end else begin
				mag = biased - gewd_pkg::EXP_BIAS;
			end
		end
		if (mag != 8'd0) begin
			if (nz_count < COUNT_CAP)
				nz_count++;
			lob = 7;
			hib = 0;
			for (i = 6; i >= 0; i--)
				if (mag[i])
					lob = i;
			for (i = 0; i < 7; i++)
				if (mag[i])
					hib = i;
			if (neg)
				hib++;
			if (lob < int'(low_seen))
				low_seen = 5'(lob);
			if (hib > int'(high_seen))
				high_seen = 4'(hib);
		end
		if (ge) begin
			if (int'(low_seen) > int'(high_seen)) begin
				width = 0;
			end else begin
				case (mode_now)
					gewd_pkg::MODE_LEAD:  width = int'(high_seen) + 1;
					gewd_pkg::MODE_MINOR: width = int'(gewd_pkg::MINOR_BASE) - int'(low_seen);
					default:              width = int'(high_seen) - int'(low_seen) + 1;
				endcase
			end
			sum = {1'b0, total_bits} + (TW+1)'(width * int'(nz_count));
			total_bits = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TW-1:0];
			res.width = 4'(width);
			res.count = nz_count;
			res.gbits = 8'(width * int'(nz_count));
			res.total = total_bits;
			has_res = 1'b1;
			if (te)
				total_bits = '0;
			low_seen = gewd_pkg::EMPTY_LOW;
			high_seen = 4'd0;
			nz_count = 5'd0;
		end
	endtask

	task automatic push_word(input logic [15:0] w, input logic ge, input logic te,
			input logic typed, input group_result_t typed_res);
		logic          has_res;
		group_result_t res;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			word_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		word_valid <= 1'b1;
		value_word <= w;
		group_end <= ge;
		tensor_end <= te;
		@(posedge clk);
		while (word_stall)
			@(posedge clk);
		words_taken++;
		track_word(w, ge, te, has_res, res);
		if (has_res)
			pending_groups.insert(pending_groups.size(), typed ? typed_res : res);
	endtask

	task automatic drain_groups();
		word_valid <= 1'b0;
		while (pending_groups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_width_mode(input logic [1:0] m);
		drain_groups();
		cfg_write_en <= 1'b1;
		cfg_write_data <= m;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		mode_now = m;
		modes_seen[m] = 1'b1;
	endtask

	function automatic logic [15:0] rand_word();
		logic       s;
		logic [7:0] b;
		logic [6:0] m;
		s = 1'($urandom_range(0, 1));
		m = 7'($urandom_range(0, 127));
		b = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: return {s, 15'd0};
			1: b = 8'd0;
			2: b = gewd_pkg::EXP_SPECIAL;
			3: b = gewd_pkg::EXP_BIAS;
			4, 5: b = 8'($urandom_range(0, 255));
			default: b = 8'($urandom_range(96, 160));
		endcase
		return {s, b, m};
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		group_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				groups_seen++;
				if (pending_groups.size() == 0) begin
					report_mismatch("result with no group pending", group_width, 0);
				end else begin
					want = pending_groups.pop_front();
					if (group_width !== want.width)
						report_mismatch("group_width", group_width, want.width);
					if (nonzero_exponents !== want.count)
						report_mismatch("nonzero_exponents", nonzero_exponents, want.count);
					if (group_bits !== want.gbits)
						report_mismatch("group_bits", group_bits, want.gbits);
					if (running_bits !== want.total)
						report_mismatch("running_bits", running_bits, want.total);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		int k;
		int ph;
		int glen;
		int phase_count;
		logic ge;
		logic te;
		mode_now = gewd_pkg::MODE_SPAN;
		low_seen = gewd_pkg::EMPTY_LOW;
		high_seen = 4'd0;
		nz_count = 5'd0;
		total_bits = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NUM_ROWS; k++)
			push_word(stim_rows[k].word, stim_rows[k].ge, stim_rows[k].te,
				stim_rows[k].typed, stim_rows[k].res);
		// overlong group, count saturates
		for (k = 0; k < 18; k++)
			push_word({1'b0, gewd_pkg::EXP_BIAS + 8'(k % 6 + 1), 7'(k * 13)}, k == 17,
				1'b0, 1'b0, EMPTY_RES);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			set_width_mode(phase_modes[ph]);
			quiet = (ph == NUM_PHASES - 1);
			phase_count = 0;
			while (phase_count < PHASE_WORDS) begin
				case ($urandom_range(0, 19))
					0: glen = $urandom_range(17, 24);
					1, 2: glen = gewd_pkg::GROUP_SIZE_DEF;
					default: glen = $urandom_range(1, 15);
				endcase
				for (k = 0; k < glen; k++) begin
					ge = (k == glen - 1);
					te = ge ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 9) == 0);
					push_word(rand_word(), ge, te, 1'b0, EMPTY_RES);
				end
				phase_count += glen;
			end
		end

		drain_groups();
		$display("covered %0d words and %0d group results, width mode codes used %b",
			words_taken, groups_seen, modes_seen);
		$display("includes zeros, inf/nan, subnormals, empty and overlong groups, tensor ends");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
